// ===== hdl/rmeu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared opcodes, ALU function codes, port layout and types of the register
// machine execute unit.
// ----------------------------------------------------------------------------
package rmeu_pkg;

   // default register file depth
   localparam int NUM_REGS_DEF = 8;

   // field widths
   localparam int OP_W   = 3;
   localparam int IDX_W  = 3;
   localparam int IMM_W  = 25;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;

   // instruction opcodes (req_tuser)
   localparam logic [OP_W-1:0] OP_CMOV = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
   localparam logic [OP_W-1:0] OP_NAND = 3'd4;
   localparam logic [OP_W-1:0] OP_LDI  = 3'd5;
   localparam logic [OP_W-1:0] OP_OUT  = 3'd6;
   localparam logic [OP_W-1:0] OP_IN   = 3'd7;

   // shared ALU functions
   localparam logic [1:0] ALU_ADD  = 2'd0;
   localparam logic [1:0] ALU_MUL  = 2'd1;
   localparam logic [1:0] ALU_DIV  = 2'd2;
   localparam logic [1:0] ALU_NAND = 2'd3;

   // request tdata layout
   localparam int REQ_A_LSB    = 0;
   localparam int REQ_B_LSB    = REQ_A_LSB + IDX_W;
   localparam int REQ_C_LSB    = REQ_B_LSB + IDX_W;
   localparam int REQ_IMM_LSB  = REQ_C_LSB + IDX_W;
   localparam int REQ_BYTE_LSB = REQ_IMM_LSB + IMM_W;
   localparam int REQ_END_BIT  = REQ_BYTE_LSB + BYTE_W;
   localparam int REQ_DATA_W   = 48;

   // response tdata layout
   localparam int RSP_USED_W = BYTE_W + 1 + WORD_W;
   localparam int RSP_DATA_W = 48;

   // characters are emitted only below this value
   localparam logic [WORD_W-1:0] CHAR_LIMIT = 32'd256;

   // ALU command and status
   typedef struct packed {
      logic       start;
      logic [1:0] func;
   } alu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

endpackage

// ===== hdl/register_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes one decoded register-machine instruction per request against a
// register file and returns one response per request.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_tready is high only while the unit is
// idle. Operands are read from the register file (b and c first, then
// a), the shared ALU runs, and the result is written back as the
// response is loaded into the output register. Add, NAND, conditional move,
// load immediate, output and input finish in the ALU at start; multiply
// and divide wait for the 32 steps of the shared adder in the ALU. A
// response waiting in the output register does not stop the next request
// from being accepted and worked on. The register file reads as all zeros
// after reset, without a clearing pass. Divide by zero leaves register a
// unchanged and sets div_zero.
// ----------------------------------------------------------------------------
module register_machine_execute_unit
   import rmeu_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // reg_a[2:0], reg_b[5:3], reg_c[8:6], immediate[33:9], in_byte[41:34],
   // in_end[42], zero fill[47:43]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[2:0]
   input  logic [OP_W-1:0]       req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // char_out[7:0], div_zero[8], written_value[40:9], zero fill[47:41]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // char_valid[0]
   output logic                  rsp_tuser
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD_BC = 3'd1;
   localparam logic [2:0] ST_RD_A  = 3'd2;
   localparam logic [2:0] ST_GO    = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;

   // captured transaction
   logic [OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]  a_ff, b_ff, c_ff;
   logic [IMM_W-1:0]  imm_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              end_ff;

   // operands
   logic [WORD_W-1:0] opa_ff, opb_ff, opc_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              rsp_user_ff;

   logic              req_accept, rsp_load;
   logic [IDX_W-1:0]  rd0_idx;
   logic [WORD_W-1:0] rd0_data, rd1_data;

   alu_ctrl_type      alu_ctrl;
   alu_stat_type      alu_stat;
   logic [WORD_W-1:0] alu_result;

   // writeback and response fields
   logic              wb_en, rf_we;
   logic [IDX_W-1:0]  wb_idx;
   logic [WORD_W-1:0] wb_data, dest_val, written_value;
   logic              dest_ok, char_valid, div_zero;
   logic [BYTE_W-1:0] char_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rf_we      = rsp_load && wb_en;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_RD_BC;
         ST_RD_BC: state_in = ST_RD_A;
         ST_RD_A:  state_in = ST_GO;
         ST_GO:    state_in = ST_EXEC;
         ST_EXEC:  if (alu_stat.done) state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture request fields
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tuser;
         a_ff    <= req_tdata[REQ_A_LSB +: IDX_W];
         b_ff    <= req_tdata[REQ_B_LSB +: IDX_W];
         c_ff    <= req_tdata[REQ_C_LSB +: IDX_W];
         imm_ff  <= req_tdata[REQ_IMM_LSB +: IMM_W];
         byte_ff <= req_tdata[REQ_BYTE_LSB +: BYTE_W];
         end_ff  <= req_tdata[REQ_END_BIT];
      end
   end

   // operand reads: b and c first, then a on port 0
   assign rd0_idx = (state_ff == ST_RD_BC) ? b_ff : a_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_RD_A) begin
         opb_ff <= rd0_data;
         opc_ff <= rd1_data;
      end
      if (state_ff == ST_GO) begin
         opa_ff <= rd0_data;
      end
   end

   rmeu_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd0_idx  (rd0_idx),
      .rd1_idx  (c_ff),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data),
      .wr_en    (rf_we),
      .wr_idx   (wb_idx),
      .wr_data  (wb_data)
   );

   // ALU launch
   always_comb begin
      alu_ctrl.start = (state_ff == ST_GO);
      unique case (op_ff)
         OP_MUL:  alu_ctrl.func = ALU_MUL;
         OP_DIV:  alu_ctrl.func = ALU_DIV;
         OP_NAND: alu_ctrl.func = ALU_NAND;
         default: alu_ctrl.func = ALU_ADD;
      endcase
   end

   rmeu_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opnd_b (opb_ff),
      .opnd_c (opc_ff),
      .stat   (alu_stat),
      .result (alu_result)
   );

   // writeback value and response fields
   always_comb begin
      wb_en      = 1'b0;
      wb_idx     = a_ff;
      wb_data    = alu_result;
      dest_val   = opa_ff;
      dest_ok    = 32'(a_ff) < NUM_REGS;
      char_valid = 1'b0;
      char_out   = '0;
      div_zero   = 1'b0;
      unique case (op_ff)
         OP_CMOV: begin
            if (opc_ff != '0) begin
               wb_en    = 1'b1;
               wb_data  = opb_ff;
               dest_val = opb_ff;
            end
         end
         OP_ADD, OP_MUL, OP_NAND: begin
            wb_en    = 1'b1;
            dest_val = alu_result;
         end
         OP_DIV: begin
            if (opc_ff == '0) begin
               div_zero = 1'b1;
            end else begin
               wb_en    = 1'b1;
               dest_val = alu_result;
            end
         end
         OP_LDI: begin
            wb_en    = 1'b1;
            wb_data  = WORD_W'(imm_ff);
            dest_val = WORD_W'(imm_ff);
         end
         OP_OUT: begin
            dest_val = '0;
            if (opc_ff < CHAR_LIMIT) begin
               char_valid = 1'b1;
               char_out   = opc_ff[BYTE_W-1:0];
            end
         end
         OP_IN: begin
            wb_en    = 1'b1;
            wb_idx   = c_ff;
            dest_ok  = 32'(c_ff) < NUM_REGS;
            wb_data  = end_ff ? '1 : WORD_W'(byte_ff);
            dest_val = end_ff ? '1 : WORD_W'(byte_ff);
         end
      endcase
      written_value = dest_ok ? dest_val : '0;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {(RSP_DATA_W - RSP_USED_W)'(0), written_value, div_zero, char_out};
         rsp_user_ff <= char_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // waiting in EXEC needs a running or finished ALU
   a_exec_alu_active : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (alu_stat.busy || alu_stat.done))
      else $error("EXEC with idle ALU");

   // a register write never overlaps a new transaction
   a_no_write_on_accept : assert property (@(posedge clock) disable iff (reset)
      !(rf_we && req_accept))
      else $error("register write during accept");

   // accepted transaction closes the request side
   a_accept_closes : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready && (state_ff == ST_RD_BC))
      else $error("request side still open after accept");

endmodule

// ===== hdl/rmeu_regfile.sv =====
// ----------------------------------------------------------------------------
// rmeu_regfile
// Register file memory: one write port, two registered read ports. Per-entry
// valid bits make unwritten entries read as zero after reset; indexes at or
// beyond the depth read as zero and ignore writes.
// ----------------------------------------------------------------------------
module rmeu_regfile
   import rmeu_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  rd0_idx,
   input  logic [IDX_W-1:0]  rd1_idx,
   output logic [WORD_W-1:0] rd0_data,
   output logic [WORD_W-1:0] rd1_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [WORD_W-1:0] wr_data
);

   localparam int AW = $clog2(NUM_REGS);

   logic [WORD_W-1:0]   mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [WORD_W-1:0]   rd0_mem_ff, rd1_mem_ff;
   logic                rd0_hit_ff, rd1_hit_ff;
   logic                wr_ok, rd0_ok, rd1_ok;

   assign wr_ok  = 32'(wr_idx)  < NUM_REGS;
   assign rd0_ok = 32'(rd0_idx) < NUM_REGS;
   assign rd1_ok = 32'(rd1_idx) < NUM_REGS;

   // valid bits: set on first write
   always_comb begin
      valid_in = valid_ff;
      if (wr_en && wr_ok) begin
         valid_in[AW'(wr_idx)] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory write
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[AW'(wr_idx)] <= wr_data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rd0_mem_ff <= mem[AW'(rd0_idx)];
      rd1_mem_ff <= mem[AW'(rd1_idx)];
      rd0_hit_ff <= rd0_ok && valid_ff[AW'(rd0_idx)];
      rd1_hit_ff <= rd1_ok && valid_ff[AW'(rd1_idx)];
   end

   assign rd0_data = rd0_hit_ff ? rd0_mem_ff : '0;
   assign rd1_data = rd1_hit_ff ? rd1_mem_ff : '0;

endmodule

// ===== hdl/rmeu_alu.sv =====
// ----------------------------------------------------------------------------
// rmeu_alu
// Shared arithmetic unit around one 34-bit adder/subtractor. Add and NAND
// finish at start; multiply (shift-add) and divide (restoring, radix 2) take
// 32 steps on the same adder.
// ----------------------------------------------------------------------------
module rmeu_alu
   import rmeu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_ctrl_type      ctrl,
   input  logic [WORD_W-1:0] opnd_b,
   input  logic [WORD_W-1:0] opnd_c,
   output alu_stat_type      stat,
   output logic [WORD_W-1:0] result
);

   localparam int SUM_W = WORD_W + 2;
   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        func_ff, func_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] acc_ff, acc_in;     // product / remainder
   logic [WORD_W-1:0] mq_ff, mq_in;       // multiplier / quotient
   logic [WORD_W-1:0] opnd_ff, opnd_in;   // multiplicand / divisor

   logic [SUM_W-1:0]  add_x, add_y, add_sum;
   logic              add_sub;

   // shared adder operand select
   always_comb begin
      add_x   = {2'b00, opnd_b};
      add_y   = {2'b00, opnd_c};
      add_sub = 1'b0;
      if (!ctrl.start && func_ff == ALU_MUL) begin
         add_x = {2'b00, acc_ff};
         add_y = {2'b00, opnd_ff};
      end else if (!ctrl.start && func_ff == ALU_DIV) begin
         add_x   = {1'b0, acc_ff, mq_ff[WORD_W-1]};
         add_y   = {2'b00, opnd_ff};
         add_sub = 1'b1;
      end
   end

   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + SUM_W'(add_sub);

   // step sequencing
   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      func_in  = func_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      mq_in    = mq_ff;
      opnd_in  = opnd_ff;
      if (ctrl.start) begin
         func_in  = ctrl.func;
         count_in = '1;
         unique case (ctrl.func)
            ALU_ADD: begin
               acc_in  = add_sum[WORD_W-1:0];
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            ALU_NAND: begin
               acc_in  = ~(opnd_b & opnd_c);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            ALU_MUL: begin
               acc_in  = '0;
               mq_in   = opnd_c;
               opnd_in = opnd_b;
               busy_in = 1'b1;
               done_in = 1'b0;
            end
            ALU_DIV: begin
               acc_in  = '0;
               mq_in   = opnd_b;
               opnd_in = opnd_c;
               busy_in = 1'b1;
               done_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (func_ff == ALU_MUL) begin
            if (mq_ff[0]) begin
               acc_in = add_sum[WORD_W-1:0];
            end
            mq_in   = {1'b0, mq_ff[WORD_W-1:1]};
            opnd_in = {opnd_ff[WORD_W-2:0], 1'b0};
         end else begin
            // restoring divide: keep difference when no borrow
            if (!add_sum[SUM_W-1]) begin
               acc_in = add_sum[WORD_W-1:0];
               mq_in  = {mq_ff[WORD_W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[WORD_W-2:0], mq_ff[WORD_W-1]};
               mq_in  = {mq_ff[WORD_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      mq_ff    <= mq_in;
      opnd_ff  <= opnd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = (func_ff == ALU_DIV) ? mq_ff : acc_ff;

   // busy and done are exclusive
   a_busy_done_excl : assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("alu busy and done together");

   // last step raises done
   a_last_step_done : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctrl.start && count_ff == '0) |=> done_ff)
      else $error("alu did not finish after last step");

endmodule
